// ----- sv/sct_pkg.sv -----
package sct_pkg;

  // Timestamp and counter widths
  localparam int TS_W         = 64;
  localparam int ELAPSED_BITS = 48;
  localparam int FRAC_SHIFT   = 16;
  localparam int QUOT_BITS    = TS_W - FRAC_SHIFT;
  localparam int REM_W        = 10;
  localparam int EXP_W        = 5;
  localparam int CNT_W        = 32;

  // Poll exponent limits and related constants
  localparam logic [EXP_W-1:0] POLL_LO     = 5'd4;
  localparam logic [EXP_W-1:0] POLL_HI     = 5'd17;
  localparam logic [7:0]       STRATUM_MAX = 8'd15;
  localparam logic [CNT_W-1:0] MS_PER_S    = 32'd1000;
  localparam logic [EXP_W-1:0] MIN_RESET   = 5'd6;
  localparam logic [EXP_W-1:0] MAX_RESET   = 5'd10;

  // One millisecond is 65536/1000 = 65 rem 536 in the scaled quotient
  localparam logic [QUOT_BITS-1:0] TICK_QUOT     = QUOT_BITS'(65);
  localparam logic [REM_W:0]       TICK_REM      = 11'd536;
  localparam logic [REM_W:0]       REM_MOD       = 11'd1000;

  // One second in 32.32 format, and its negative
  localparam logic [TS_W-1:0] STEP_LIMIT     = 64'h0000_0001_0000_0000;
  localparam logic [TS_W-1:0] NEG_STEP_LIMIT = 64'hFFFF_FFFF_0000_0000;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_REQUEST  = 2'd1,
    CMD_RESPONSE = 2'd2,
    CMD_FAIL     = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_SLEW    = 3'd1,
    ST_STEP    = 3'd2,
    ST_ORIGIN  = 3'd3,
    ST_STRATUM = 3'd4,
    ST_XPORT   = 3'd5
  } status_e;

  typedef enum logic {
    CFG_MIN_POLL = 1'b0,
    CFG_MAX_POLL = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    cmd_e            cmd;
    logic            force_step;
    logic [7:0]      stratum;
    logic [7:0]      server_poll;
    logic [TS_W-1:0] origin_time;
    logic [TS_W-1:0] receive_time;
    logic [TS_W-1:0] transmit_time;
  } item_t;

  typedef struct packed {
    status_e          status;
    logic [TS_W-1:0]  local_time;
    logic [TS_W-1:0]  offset;
    logic [EXP_W-1:0] poll_exponent;
    logic             synchronized;
    logic             poll_due;
  } result_t;

  // Handshake between the input stage and the core
  typedef struct packed {
    logic valid;
  } stage_ctl_t;

  function automatic logic [EXP_W-1:0] clamp_exp(input logic [EXP_W-1:0] e);
    logic [EXP_W-1:0] r;
    if (e < POLL_LO) r = POLL_LO;
    else if (e > POLL_HI) r = POLL_HI;
    else r = e;
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] period_of(input logic [EXP_W-1:0] e);
    return MS_PER_S << clamp_exp(e);
  endfunction

  function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
  endfunction

endpackage

// ----- sv/sct_in_stage.sv -----
module sct_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sct_pkg::item_t    item_i,
  input  logic              take_i,
  output sct_pkg::stage_ctl_t ctl_o,
  output sct_pkg::item_t    item_o
);
  import sct_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Accept when empty or when the held item moves on this cycle
  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;
  assign valid_d    = load || (valid_q && !take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Capture the payload on each transfer
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign ctl_o.valid = valid_q;
  assign item_o      = item_q;

endmodule

// ----- sv/sct_core.sv -----
module sct_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [4:0]          cfg_wdata_i,
  input  sct_pkg::stage_ctl_t ctl_i,
  input  sct_pkg::item_t      item_i,
  output logic                take_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sct_pkg::result_t    res_o
);
  import sct_pkg::*;

  // Configuration
  logic [EXP_W-1:0] min_q, max_q;

  // Timekeeping state
  logic [TS_W-1:0]         base_q, base_d;
  logic [TS_W-1:0]         now_q, now_d;
  logic [ELAPSED_BITS-1:0] ms_q, ms_d;
  logic [QUOT_BITS-1:0]    quot_q, quot_d;
  logic [REM_W-1:0]        rem_q, rem_d;
  logic [CNT_W-1:0]        upd_q, upd_d;
  logic [CNT_W-1:0]        period_q, period_d;
  logic [EXP_W-1:0]        poll_q, poll_d;
  logic                    synced_q, synced_d;
  logic [TS_W-1:0]         req_q, req_d;

  // Result register
  logic    out_valid_q;
  result_t res_q, res_d;

  // Datapath temporaries
  logic [REM_W:0]      rem_sum;
  logic [TS_W-1:0]     diff_rx, diff_tx;
  logic [TS_W:0]       sum65, adj65;
  logic [TS_W-1:0]     theta;
  logic                big_offset;
  logic [EXP_W-1:0]    lo_exp, hi_exp;
  status_e             status;
  logic [TS_W-1:0]     offset;

  assign take_o = ctl_i.valid && (!out_valid_q || out_ready_i);

  // Offset: exact halved sum of both differences, truncated toward zero
  assign diff_rx    = item_i.receive_time - req_q;
  assign diff_tx    = item_i.transmit_time - now_q;
  assign sum65      = {diff_rx[TS_W-1], diff_rx} + {diff_tx[TS_W-1], diff_tx};
  assign adj65      = sum65 + {{TS_W{1'b0}}, sum65[TS_W]};
  assign theta      = adj65[TS_W:1];
  assign big_offset = theta[TS_W-1] ? ($signed(theta) < $signed(NEG_STEP_LIMIT))
                                    : (theta > STEP_LIMIT);
  assign lo_exp     = clamp_exp(min_q);
  assign hi_exp     = clamp_exp(max_q);
  assign rem_sum    = {1'b0, rem_q} + TICK_REM;

  // Next state and result for the held item
  always_comb begin
    base_d   = base_q;
    now_d    = now_q;
    ms_d     = ms_q;
    quot_d   = quot_q;
    rem_d    = rem_q;
    upd_d    = upd_q;
    period_d = period_q;
    poll_d   = poll_q;
    synced_d = synced_q;
    req_d    = req_q;
    status   = ST_NONE;
    offset   = '0;

    case (item_i.cmd)
      CMD_TICK: begin
        ms_d = ms_q + ELAPSED_BITS'(1);
        if (&ms_q) begin
          quot_d = '0;
          rem_d  = '0;
        end else if (rem_sum >= REM_MOD) begin
          rem_d  = REM_W'(rem_sum - REM_MOD);
          quot_d = quot_q + TICK_QUOT + QUOT_BITS'(1);
        end else begin
          rem_d  = rem_sum[REM_W-1:0];
          quot_d = quot_q + TICK_QUOT;
        end
        if (upd_q != {CNT_W{1'b1}}) begin
          upd_d = upd_q + CNT_W'(1);
        end
        now_d = base_q + {quot_d, {FRAC_SHIFT{1'b0}}};
      end
      CMD_REQUEST: begin
        synced_d = 1'b0;
        req_d    = now_q;
      end
      CMD_RESPONSE: begin
        if (item_i.origin_time != req_q) begin
          synced_d = 1'b0;
          period_d = sat_add32(period_q, MS_PER_S);
          status   = ST_ORIGIN;
        end else if (item_i.stratum == 8'd0 || item_i.stratum > STRATUM_MAX) begin
          synced_d = 1'b0;
          period_d = sat_add32(period_q, period_of(lo_exp));
          status   = ST_STRATUM;
        end else begin
          upd_d = '0;
          if (item_i.server_poll < {3'b000, lo_exp}) poll_d = lo_exp;
          else if (item_i.server_poll > {3'b000, hi_exp}) poll_d = hi_exp;
          else poll_d = item_i.server_poll[EXP_W-1:0];
          period_d = period_of(poll_d);
          offset   = theta;
          if (item_i.force_step || big_offset) begin
            base_d = item_i.transmit_time;
            now_d  = item_i.transmit_time;
            ms_d   = '0;
            quot_d = '0;
            rem_d  = '0;
            status = ST_STEP;
          end else begin
            base_d = base_q + theta;
            now_d  = now_q + theta;
            status = ST_SLEW;
          end
          synced_d = 1'b1;
        end
      end
      CMD_FAIL: begin
        synced_d = 1'b0;
        period_d = sat_add32(period_q, MS_PER_S);
        status   = ST_XPORT;
      end
      default: begin
        status = ST_NONE;
      end
    endcase

    res_d.status        = status;
    res_d.local_time    = now_d;
    res_d.offset        = offset;
    res_d.poll_exponent = poll_d;
    res_d.synchronized  = synced_d && (upd_d < period_of(poll_d));
    res_d.poll_due      = !synced_d || (upd_d >= period_d);
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= MIN_RESET;
      max_q <= MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_POLL: min_q <= cfg_wdata_i;
        CFG_MAX_POLL: max_q <= cfg_wdata_i;
        default:      min_q <= min_q;
      endcase
    end
  end

  // Advance state on each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q   <= '0;
      now_q    <= '0;
      ms_q     <= '0;
      quot_q   <= '0;
      rem_q    <= '0;
      upd_q    <= '0;
      period_q <= '0;
      poll_q   <= MIN_RESET;
      synced_q <= 1'b0;
      req_q    <= '0;
    end else if (take_o) begin
      base_q   <= base_d;
      now_q    <= now_d;
      ms_q     <= ms_d;
      quot_q   <= quot_d;
      rem_q    <= rem_d;
      upd_q    <= upd_d;
      period_q <= period_d;
      poll_q   <= poll_d;
      synced_q <= synced_d;
      req_q    <= req_d;
    end
  end

  // Hold the result until the transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- sv/sntp_client_timekeeper.sv -----
// SNTP client timekeeper. Keeps a 32.32 local clock (base plus scaled elapsed
// milliseconds), captures t1 on request, validates responses by origin and
// stratum, computes the offset and either slews or steps the clock, and
// manages the poll exponent and poll period. Takes one item per clock cycle
// while the output is not stalled: each item is held in the input register,
// then all state updates and the result are formed in one pass into the
// result register. The millisecond-to-fraction conversion is kept as a
// running quotient and remainder, so a tick costs a small remainder add, a
// quotient add and one 64-bit add. Configuration writes take effect on the
// next cycle and should be done only while no item is in flight.
module sntp_client_timekeeper (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [4:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic               force_step_i,
  input  logic [7:0]         stratum_i,
  input  logic [7:0]         server_poll_i,
  input  logic [63:0]        origin_time_i,
  input  logic [63:0]        receive_time_i,
  input  logic [63:0]        transmit_time_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [63:0]        local_time_o,
  output logic signed [63:0] offset_o,
  output logic [4:0]         poll_exponent_o,
  output logic               synchronized_o,
  output logic               poll_due_o
);
  import sct_pkg::*;

  item_t      item_in, item_held;
  stage_ctl_t ctl;
  logic       take;
  result_t    res;

  // Pack the input payload
  assign item_in.cmd           = cmd_e'(cmd_i);
  assign item_in.force_step    = force_step_i;
  assign item_in.stratum       = stratum_i;
  assign item_in.server_poll   = server_poll_i;
  assign item_in.origin_time   = origin_time_i;
  assign item_in.receive_time  = receive_time_i;
  assign item_in.transmit_time = transmit_time_i;

  sct_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (item_in),
    .take_i     (take),
    .ctl_o      (ctl),
    .item_o     (item_held)
  );

  sct_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctl_i       (ctl),
    .item_i      (item_held),
    .take_o      (take),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (res)
  );

  // Unpack the result
  assign status_o        = res.status;
  assign local_time_o    = res.local_time;
  assign offset_o        = $signed(res.offset);
  assign poll_exponent_o = res.poll_exponent;
  assign synchronized_o  = res.synchronized;
  assign poll_due_o      = res.poll_due;

endmodule

// ----- sv/sct_checker.sv -----
module sct_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [63:0] offset_o,
  input logic [4:0]  poll_exponent_o,
  input logic        synchronized_o,
  input logic        poll_due_o
);
  import sct_pkg::*;

  // Hold a pending result until its transfer
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(offset_o))
    else $error("result changed or dropped while stalled");

  // Poll exponent stays in the legal window
  a_poll_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> poll_exponent_o >= POLL_LO && poll_exponent_o <= POLL_HI)
    else $error("poll exponent out of range");

  // A good response leaves the clock synchronized and no poll due
  a_good_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_SLEW || status_o == ST_STEP)
      |-> synchronized_o && !poll_due_o)
    else $error("good response not synchronized");

  // Any failure drops sync and asks for a poll
  a_fail_unsync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_ORIGIN || status_o == ST_STRATUM
      || status_o == ST_XPORT) |-> !synchronized_o && poll_due_o)
    else $error("failure left clock synchronized");

  // Offset is reported only with a good response
  a_offset_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_SLEW && status_o != ST_STEP |-> offset_o == 64'd0)
    else $error("offset reported without good response");

endmodule

bind sntp_client_timekeeper sct_checker u_sct_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .status_o        (status_o),
  .offset_o        (offset_o),
  .poll_exponent_o (poll_exponent_o),
  .synchronized_o  (synchronized_o),
  .poll_due_o      (poll_due_o)
);
